/* hdl/cfwah_pkg.sv */
package cfwah_pkg;

  // default sizes
  localparam int MaxDelayDef = 128;
  localparam int LutBitsDef  = 10;

  // port and datapath widths
  localparam int SmpW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;
  localparam int LineW    = 20;
  localparam int CoefW    = 18;
  localparam int AccW     = 52;

  // fixed-point constants
  localparam logic [16:0]    FbOne    = 17'd65536;
  localparam logic [6:0]     DelayMin = 7'd5;
  localparam longint         OneQ30   = 64'sd1073741824;
  localparam longint unsigned TwoPiQ30 = 64'd6746518852;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PHASE_STEP,
    REG_FEEDBACK,
    REG_DELAY_LENGTH,
    REG_COEF_INTERVAL,
    REG_CHANNEL_COUNT
  } cfg_reg_e;

  typedef struct packed {
    logic [30:0] phase_step;
    logic [16:0] feedback;
    logic [6:0]  delay_length;
    logic [8:0]  coef_interval;
    logic [3:0]  channel_count;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LOOK,
    B_COEF_RE,
    B_COEF_IM,
    B_MAC0,
    B_MAC1,
    B_MAC2,
    B_MAC3,
    B_MAC4,
    B_STORE
  } back_state_e;

  // truncating taylor series of cos and sin, q30 in and out, packed {cos, sin}
  function automatic logic [63:0] taylor(input longint unsigned x);
    longint unsigned term;
    longint          c;
    longint          s;
    term = 64'(OneQ30);
    c    = OneQ30;
    s    = 0;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * x) >> 30) / 64'(k);
      case (k % 4)
        1:       s = s + longint'(term);
        2:       c = c - longint'(term);
        3:       s = s - longint'(term);
        default: c = c + longint'(term);
      endcase
    end
    return {c[31:0], s[31:0]};
  endfunction

  // cos and sin of 1 + cos(2 pi idx / 2^lb), packed {cos, sin} in q30
  function automatic logic [63:0] trig_entry(input int idx, input int lb);
    longint unsigned x;
    logic [63:0]     cs;
    longint          cv;
    longint          sv;
    longint          u;
    longint          t;
    int              quarter;
    int              r;
    quarter = (idx >> (lb - 2)) & 3;
    r       = idx & ((1 << (lb - 2)) - 1);
    x       = (64'(r) * TwoPiQ30) >> lb;
    cs      = taylor(x);
    cv      = longint'(signed'(cs[63:32]));
    sv      = longint'(signed'(cs[31:0]));
    case (quarter)
      0:       u = cv;
      1:       u = -sv;
      2:       u = -cv;
      default: u = sv;
    endcase
    t = OneQ30 + u;
    if (t < 0) t = 0;
    if (t > 2 * OneQ30) t = 2 * OneQ30;
    return taylor(64'(t));
  endfunction

  // shift right with rounding half away from zero
  function automatic logic signed [AccW-1:0] rnd_shr(input logic signed [AccW-1:0] v,
                                                      input int sh);
    logic signed [AccW-1:0] m;
    m = v[AccW-1] ? -v : v;
    m = (m + (AccW'(1) <<< (sh - 1))) >>> sh;
    return v[AccW-1] ? -m : m;
  endfunction

  function automatic logic signed [CoefW-1:0] sat_coef(input logic signed [AccW-1:0] v);
    if (v > AccW'(131071)) return CoefW'(131071);
    if (v < -AccW'(131072)) return -CoefW'(131072);
    return CoefW'(v);
  endfunction

  function automatic logic signed [LineW-1:0] sat_line(input logic signed [AccW-1:0] v);
    if (v > AccW'(524287)) return LineW'(524287);
    if (v < -AccW'(524288)) return -LineW'(524288);
    return LineW'(v);
  endfunction

  function automatic logic signed [SmpW-1:0] sat_smp(input logic signed [LineW+1:0] v);
    if (v > (LineW + 2)'(32767)) return SmpW'(32767);
    if (v < -(LineW + 2)'(32768)) return -SmpW'(32768);
    return SmpW'(v);
  endfunction

endpackage

/* hdl/cfwah_if.sv */
interface cfwah_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] audio_in;
  modport source (output valid, audio_in, input ready);
  modport sink (input valid, audio_in, output ready);
endinterface

interface cfwah_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] audio_out;
  modport source (output valid, audio_out, input ready);
  modport sink (input valid, audio_out, output ready);
endinterface

interface cfwah_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/cfwah_front.sv */
module cfwah_front #(
  parameter int LUT_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cfwah_in_if.sink            smp_in_i,
  cfwah_cfg_if.sink           cfg_i,
  output cfwah_pkg::cfg_t     cfg_o,
  output logic                push_o,
  output logic [LUT_BITS+16:0] push_data_o,
  input  logic                full_i
);
  import cfwah_pkg::*;

  cfg_t        cfg_q;
  logic [2:0]  chan_q;
  logic [7:0]  frame_q;
  logic [31:0] lfo_q;
  logic [3:0]  chans_eff;
  logic [8:0]  interval_eff;
  logic [8:0]  frame_inc;
  logic        last_chan;
  logic        refresh;

  // configuration registers, always writable
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step    <= 31'd894785;
      cfg_q.feedback      <= 17'd58982;
      cfg_q.delay_length  <= 7'd50;
      cfg_q.coef_interval <= 9'd16;
      cfg_q.channel_count <= 4'd2;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_PHASE_STEP:    cfg_q.phase_step    <= cfg_i.data;
        REG_FEEDBACK:      cfg_q.feedback      <= cfg_i.data[16:0];
        REG_DELAY_LENGTH:  cfg_q.delay_length  <= cfg_i.data[6:0];
        REG_COEF_INTERVAL: cfg_q.coef_interval <= cfg_i.data[8:0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  // frame and refresh bookkeeping
  always_comb begin
    chans_eff    = (cfg_q.channel_count == 4'd0) ? 4'd1 :
                   (cfg_q.channel_count > 4'd8) ? 4'd8 : cfg_q.channel_count;
    interval_eff = (cfg_q.coef_interval == 9'd0) ? 9'd1 :
                   (cfg_q.coef_interval > 9'd256) ? 9'd256 : cfg_q.coef_interval;
    last_chan    = (4'(chan_q) + 4'd1) >= chans_eff;
    frame_inc    = 9'(frame_q) + 9'd1;
    refresh      = (chan_q == 3'd0) && (frame_q == 8'd0);
  end

  assign smp_in_i.ready = !full_i;
  assign push_o         = smp_in_i.valid && !full_i;
  assign push_data_o    = {refresh, lfo_q[31 -: LUT_BITS], smp_in_i.audio_in};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= '0;
      frame_q <= '0;
      lfo_q   <= '0;
    end else if (push_o) begin
      if (last_chan) begin
        chan_q  <= '0;
        lfo_q   <= lfo_q + 32'(cfg_q.phase_step);
        frame_q <= (frame_inc >= interval_eff) ? 8'd0 : frame_inc[7:0];
      end else begin
        chan_q <= chan_q + 3'd1;
      end
    end
  end

endmodule

/* hdl/cfwah_fifo.sv */
module cfwah_fifo #(
  parameter int W = 27
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] pop_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_q;
  logic         rd_q;
  logic [1:0]   cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  // two-entry queue between front and back
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

/* hdl/cfwah_back.sv */
module cfwah_back #(
  parameter int MAX_DELAY = 128,
  parameter int LUT_BITS  = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfwah_pkg::cfg_t      cfg_i,
  input  logic                 item_valid_i,
  input  logic [LUT_BITS+16:0] item_data_i,
  output logic                 pop_o,
  cfwah_out_if.source          smp_out_o
);
  import cfwah_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);
  localparam int EW = AW + 8;

  back_state_e st_q, st_d;

  logic signed [SmpW-1:0]  smp_q;
  logic                    ref_q;
  logic [LUT_BITS-1:0]     idx_q;
  logic [63:0]             rom_q;
  logic signed [LineW-1:0] dr_q, di_q, dr_eff, di_eff;
  logic                    rdv_q;
  logic signed [CoefW-1:0] cre_q, cim_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [LineW-1:0] re_q;
  logic signed [LineW-1:0] im_new;
  logic signed [LineW+1:0] triple;
  logic [AW-1:0]           wp_q;
  logic                    full_q;
  logic                    out_valid_q;
  logic signed [SmpW-1:0]  out_q;
  logic signed [LineW-1:0] line_re [MAX_DELAY];
  logic signed [LineW-1:0] line_im [MAX_DELAY];
  logic [63:0]             rom_w [2**LUT_BITS];

  logic [16:0]             fb_eff;
  logic [6:0]              d_min;
  logic [EW-1:0]           d_ext, d_eff, rd_sum;
  logic [AW-1:0]           rd_addr;
  logic signed [18:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic signed [AccW-1:0]  prod;
  logic                    store_en;

  // coefficient table, cos and sin of 1 + cos(phase)
  for (genvar g = 0; g < 2**LUT_BITS; g++) begin : g_rom
    assign rom_w[g] = trig_entry(g, LUT_BITS);
  end

  // effective feedback and read slot
  always_comb begin
    fb_eff  = (cfg_i.feedback > FbOne) ? FbOne : cfg_i.feedback;
    d_min   = (cfg_i.delay_length < DelayMin) ? DelayMin : cfg_i.delay_length;
    d_ext   = EW'(d_min);
    d_eff   = (d_ext > EW'(MAX_DELAY - 1)) ? EW'(MAX_DELAY - 1) : d_ext;
    rd_sum  = EW'(wp_q) + EW'(MAX_DELAY) - d_eff;
    if (rd_sum >= EW'(MAX_DELAY)) rd_sum = rd_sum - EW'(MAX_DELAY);
    rd_addr = rd_sum[AW-1:0];
    dr_eff  = rdv_q ? dr_q : '0;
    di_eff  = rdv_q ? di_q : '0;
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE:    if (item_valid_i) st_d = B_LOOK;
      B_LOOK:    st_d = ref_q ? B_COEF_RE : B_MAC0;
      B_COEF_RE: st_d = B_COEF_IM;
      B_COEF_IM: st_d = B_MAC0;
      B_MAC0:    st_d = B_MAC1;
      B_MAC1:    st_d = B_MAC2;
      B_MAC2:    st_d = B_MAC3;
      B_MAC3:    st_d = B_MAC4;
      B_MAC4:    st_d = B_STORE;
      B_STORE:   if (!out_valid_q || smp_out_o.ready) st_d = B_IDLE;
      default:   st_d = B_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operand select
  always_comb begin
    pop_o    = (st_q == B_IDLE) && item_valid_i;
    store_en = (st_q == B_STORE) && (!out_valid_q || smp_out_o.ready);
    mul_a    = '0;
    mul_b    = '0;
    case (st_q)
      B_COEF_RE: begin
        mul_a = signed'({2'b00, fb_eff});
        mul_b = signed'(rom_q[63:32]);
      end
      B_COEF_IM: begin
        mul_a = signed'({2'b00, fb_eff});
        mul_b = signed'(rom_q[31:0]);
      end
      B_MAC0: begin
        mul_a = 19'(cre_q);
        mul_b = 32'(dr_eff);
      end
      B_MAC1: begin
        mul_a = 19'(cim_q);
        mul_b = 32'(di_eff);
      end
      B_MAC2: begin
        mul_a = signed'(19'd131072 - 19'({fb_eff, 1'b0}));
        mul_b = 32'(smp_q);
      end
      B_MAC3: begin
        mul_a = 19'(cre_q);
        mul_b = 32'(di_eff);
      end
      B_MAC4: begin
        mul_a = 19'(cim_q);
        mul_b = 32'(dr_eff);
      end
      default: ;
    endcase
  end

  assign prod   = AccW'(mul_a * mul_b);
  assign im_new = sat_line(rnd_shr(acc_q, 17));
  assign triple = (LineW + 2)'(re_q) + ((LineW + 2)'(re_q) <<< 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= B_IDLE;
    else         st_q <= st_d;
  end

  // item capture, table and line reads, multiply-accumulate
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      smp_q <= signed'(item_data_i[15:0]);
      idx_q <= item_data_i[LUT_BITS+15:16];
      ref_q <= item_data_i[LUT_BITS+16];
    end
    if (st_q == B_LOOK) begin
      rom_q <= rom_w[idx_q];
      dr_q  <= line_re[rd_addr];
      di_q  <= line_im[rd_addr];
      rdv_q <= full_q || (rd_addr < wp_q);
    end
    case (st_q)
      B_MAC0:  acc_q <= prod;
      B_MAC1:  acc_q <= acc_q - prod;
      B_MAC2:  acc_q <= acc_q + prod;
      B_MAC3: begin
        re_q  <= sat_line(rnd_shr(acc_q, 17));
        acc_q <= prod;
      end
      B_MAC4:  acc_q <= acc_q + prod;
      default: ;
    endcase
    if (store_en) begin
      line_re[wp_q] <= re_q;
      line_im[wp_q] <= im_new;
      out_q         <= sat_smp(triple);
    end
  end

  // coefficients, write pointer, fill flag, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cre_q       <= '0;
      cim_q       <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == B_COEF_RE) cre_q <= sat_coef(rnd_shr(prod, 29));
      if (st_q == B_COEF_IM) cim_q <= sat_coef(rnd_shr(prod, 29));
      if (store_en) begin
        if (wp_q == AW'(MAX_DELAY - 1)) begin
          wp_q   <= '0;
          full_q <= 1'b1;
        end else begin
          wp_q <= wp_q + AW'(1);
        end
      end
      if (store_en) out_valid_q <= 1'b1;
      else if (smp_out_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign smp_out_o.valid     = out_valid_q;
  assign smp_out_o.audio_out = out_q;

endmodule

/* hdl/complex_feedback_wah_top.sv */
// Complex feedback comb wah: one signed 16-bit word in, one word out. The front
// accepts words into a two-entry queue. The back runs each word through a single
// 19x32 multiplier in sequence: idle/pop, look (table and line read), five
// multiply-accumulate steps and store. The first word of every coefficient
// refresh frame also passes one coefficient step for each coefficient part.
// The store waits while the previous output word is still unaccepted. The
// delay line needs no clearing after reset: slots not yet written read as zero.
// Configuration writes are accepted every cycle and must only be issued while no
// word is in flight.
module complex_feedback_wah_top #(
  parameter int MAX_DELAY = cfwah_pkg::MaxDelayDef,
  parameter int LUT_BITS  = cfwah_pkg::LutBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfwah_in_if.sink     smp_in_i,
  cfwah_out_if.source  smp_out_o,
  cfwah_cfg_if.sink    cfg_i
);
  import cfwah_pkg::*;

  localparam int ItemW = LUT_BITS + 17;

  cfg_t             cfg;
  logic             push;
  logic [ItemW-1:0] push_data;
  logic             full;
  logic             pop;
  logic             item_valid;
  logic [ItemW-1:0] item_data;

  // accept and tag words
  cfwah_front #(
    .LUT_BITS (LUT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_in_i    (smp_in_i),
    .cfg_i       (cfg_i),
    .cfg_o       (cfg),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // decoupling queue
  cfwah_fifo #(
    .W (ItemW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (item_valid),
    .pop_data_o  (item_data)
  );

  // filter datapath
  cfwah_back #(
    .MAX_DELAY (MAX_DELAY),
    .LUT_BITS  (LUT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_data_i  (item_data),
    .pop_o        (pop),
    .smp_out_o    (smp_out_o)
  );

endmodule

/* hdl/cfwah_checker.sv */
module cfwah_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_data_i
);
  logic [2:0] pend_q;

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_valid_i && in_ready_i) - 3'(out_valid_i && out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output word changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("output word without an accepted input word");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more words in flight than the block can hold");

endmodule

bind complex_feedback_wah_top cfwah_checker u_cfwah_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_in_i.valid),
  .in_ready_i  (smp_in_i.ready),
  .out_valid_i (smp_out_o.valid),
  .out_ready_i (smp_out_o.ready),
  .out_data_i  (smp_out_o.audio_out)
);

/* dv/tb_complex_feedback_wah_top.sv */
`timescale 1ns / 100ps

module tb_complex_feedback_wah_top;
  import cfwah_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cfwah_in_if  smp_in ();
  cfwah_out_if smp_out ();
  cfwah_cfg_if cfg ();

  complex_feedback_wah_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .smp_in_i  (smp_in.sink),
    .smp_out_o (smp_out.source),
    .cfg_i     (cfg.sink)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [19:0] line_re [128];
  logic signed [19:0] line_im [128];
  logic [6:0]         wr_ptr;
  logic [31:0]        lfo_phase;
  logic signed [17:0] c_re, c_im;
  int unsigned        frame_cnt, chan_idx;
  logic [30:0]        r_phase_step;
  logic [16:0]        r_feedback;
  logic [6:0]         r_delay;
  logic [8:0]         r_interval;
  logic [3:0]         r_chans;

  logic signed [15:0] pending_smp [$];
  logic signed [15:0] expected_smp [$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_send = 1'b0;
  bit  cfg_busy = 1'b0;
  int  quiet_cycles = 0;

  function automatic longint rnd_half(input longint v, input int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // truncating series for cos and sin in q30
  task automatic series_cs(input longint unsigned x, output longint cv, output longint sv);
    longint unsigned term;
    term = 64'd1073741824;
    cv = 64'sd1073741824;
    sv = 0;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * x) >> 30) / longint'(k);
      case (k % 4)
        1: sv += longint'(term);
        2: cv -= longint'(term);
        3: sv -= longint'(term);
        default: cv += longint'(term);
      endcase
    end
  endtask

  function automatic longint eff_feedback();
    return r_feedback > 17'd65536 ? 65536 : longint'(r_feedback);
  endfunction

  // new coefficient from the lfo phase
  task automatic reload_coef();
    int unsigned idx, quarter, r;
    longint unsigned x;
    longint cv, sv, u, t, fb;
    idx = lfo_phase >> 22;
    quarter = idx >> 8;
    r = idx & 8'hff;
    x = (longint'(r) * 64'd6746518852) >> 10;
    series_cs(x, cv, sv);
    case (quarter & 3)
      0: u = cv;
      1: u = -sv;
      2: u = -cv;
      default: u = sv;
    endcase
    t = clamp(64'sd1073741824 + u, 0, 64'sd2147483648);
    series_cs(longint'(t), cv, sv);
    fb = eff_feedback();
    c_re = 18'(clamp(rnd_half(fb * cv, 29), -131072, 131071));
    c_im = 18'(clamp(rnd_half(fb * sv, 29), -131072, 131071));
  endtask

  task automatic predict_wah(input logic signed [15:0] smp);
    int unsigned d, chans, intv;
    logic [6:0] rd;
    longint fb, dr, di, re, im;
    if (chan_idx == 0 && frame_cnt == 0) reload_coef();
    d = r_delay < 5 ? 5 : r_delay;
    rd = wr_ptr - 7'(d);
    dr = line_re[rd];
    di = line_im[rd];
    fb = eff_feedback();
    re = longint'(c_re) * dr - longint'(c_im) * di + 2 * (65536 - fb) * longint'(smp);
    im = longint'(c_re) * di + longint'(c_im) * dr;
    re = clamp(rnd_half(re, 17), -524288, 524287);
    im = clamp(rnd_half(im, 17), -524288, 524287);
    line_re[wr_ptr] = 20'(re);
    line_im[wr_ptr] = 20'(im);
    wr_ptr++;
    expected_smp.push_back(16'(clamp(3 * re, -32768, 32767)));
    chans = r_chans == 0 ? 1 : (r_chans > 8 ? 8 : r_chans);
    intv = r_interval == 0 ? 1 : (r_interval > 256 ? 256 : r_interval);
    if (chan_idx + 1 >= chans) begin
      chan_idx = 0;
      lfo_phase += 32'(r_phase_step);
      frame_cnt++;
      if (frame_cnt >= intv) frame_cnt = 0;
    end else begin
      chan_idx++;
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [30:0] val);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_PHASE_STEP:    r_phase_step = val;
      REG_FEEDBACK:      r_feedback = val[16:0];
      REG_DELAY_LENGTH:  r_delay = val[6:0];
      REG_COEF_INTERVAL: r_interval = val[8:0];
      default:           r_chans = val[3:0];
    endcase
  endtask

  // let everything drain, then a settling gap
  task automatic drain();
    wait (pending_smp.size() == 0 && !smp_in.valid);
    wait (expected_smp.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: pending_smp.push_back(16'sh7fff);
        1: pending_smp.push_back(16'sh8000);
        default: pending_smp.push_back(16'($urandom));
      endcase
    end
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_in.valid <= 1'b0;
      smp_in.audio_in <= '0;
    end else begin
      if (smp_in.valid && smp_in.ready) predict_wah(smp_in.audio_in);
      if ((!smp_in.valid || smp_in.ready)) begin
        if (!hold_send && pending_smp.size() > 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          smp_in.valid <= 1'b1;
          smp_in.audio_in <= pending_smp.pop_front();
        end else begin
          smp_in.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_out.ready <= 1'b0;
    end else begin
      if (smp_out.valid && smp_out.ready) begin
        if (expected_smp.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0d", $time,
                   smp_out.audio_out);
          errors++;
        end else begin
          if (smp_out.audio_out !== expected_smp[0]) begin
            $display("%0t: audio_out mismatch, expected %0d, actual %0d", $time,
                     expected_smp[0], smp_out.audio_out);
            errors++;
          end
          void'(expected_smp.pop_front());
        end
      end
      smp_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((smp_in.valid && smp_in.ready) || (smp_out.valid && smp_out.ready) ||
        (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    for (int i = 0; i < 128; i++) begin
      line_re[i] = '0;
      line_im[i] = '0;
    end
    wr_ptr = '0;
    lfo_phase = '0;
    c_re = '0;
    c_im = '0;
    frame_cnt = 0;
    chan_idx = 0;
    r_phase_step = 31'd894785;
    r_feedback = 17'd58982;
    r_delay = 7'd50;
    r_interval = 9'd16;
    r_chans = 4'd2;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes at reset settings
    pending_smp.push_back(16'sh7fff);
    pending_smp.push_back(16'sh8000);
    pending_smp.push_back(16'sh0000);
    pending_smp.push_back(-16'sd1);
    pending_smp.push_back(16'sd1);
    for (int i = 0; i < 8; i++) pending_smp.push_back(16'sh7fff);
    drain();

    // directed: out-of-range register values act clamped
    write_reg(REG_FEEDBACK, 31'h1ffff);
    write_reg(REG_DELAY_LENGTH, 31'd2);
    write_reg(REG_COEF_INTERVAL, 31'd0);
    write_reg(REG_CHANNEL_COUNT, 31'd0);
    write_reg(REG_PHASE_STEP, 31'h7fffffff);
    for (int i = 0; i < 6; i++) pending_smp.push_back(i[0] ? 16'sh8000 : 16'sh7fff);
    drain();
    write_reg(REG_DELAY_LENGTH, 31'd127);
    write_reg(REG_COEF_INTERVAL, 31'd511);
    write_reg(REG_CHANNEL_COUNT, 31'd15);
    write_reg(REG_FEEDBACK, 31'd0);
    for (int i = 0; i < 6; i++) pending_smp.push_back(16'($urandom));
    drain();

    // channel count and interval lowered mid-frame
    write_reg(REG_FEEDBACK, 31'd65536);
    write_reg(REG_CHANNEL_COUNT, 31'd1);
    write_reg(REG_COEF_INTERVAL, 31'd1);
    pending_smp.push_back(16'sd1000);
    drain();

    // random phases with varied settings and idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      write_reg(REG_PHASE_STEP, ph == 0 ? 31'd0 : 31'($urandom));
      write_reg(REG_FEEDBACK, ph == 1 ? 31'd65536 : 31'($urandom_range(0, 65536)));
      write_reg(REG_DELAY_LENGTH, ph == 2 ? 31'd5 : 31'($urandom_range(5, 127)));
      write_reg(REG_COEF_INTERVAL, ph == 3 ? 31'd256 : 31'($urandom_range(1, 20)));
      write_reg(REG_CHANNEL_COUNT, ph == 4 ? 31'd8 : 31'($urandom_range(1, 8)));
      queue_random(70);
      // hold off the sender until the block has fully drained
      wait (pending_smp.size() == 0 && !smp_in.valid);
      hold_send = 1'b1;
      wait (expected_smp.size() == 0);
      hold_send = 1'b0;
      queue_random(80);
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
